// ===== rtl/hsirgbw_pkg.sv =====
// Shared types, widths and constants of the HSI to RGB/RGBW converter.
// Also builds the cos(h)/cos(60-h) ratio table at elaboration.
// Depends on nothing; used by hsi_to_rgb_rgbw_converter_core.
package hsirgbw_pkg;

  // Item types
  typedef struct packed {
    logic       req_type;
    logic [8:0] hue_deg;
    logic [6:0] sat_pct;
    logic [6:0] int_pct;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
  } out_item_t;

  // Mode and sector codes
  localparam logic       MODE_RGB  = 1'b0;
  localparam logic       MODE_RGBW = 1'b1;
  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  // Fixed-point widths
  localparam int RATIO_FRAC_BITS = 14;
  localparam int RATIO_W = RATIO_FRAC_BITS + 2;   // signed Q2.F ratio
  localparam int SR_W    = RATIO_FRAC_BITS + 9;   // sat * ratio
  localparam int FAC_W   = RATIO_FRAC_BITS + 10;  // per-channel factor
  localparam int K_W     = 20;                    // 85*i or 85*s*i
  localparam int PROD_W  = K_W + 1 + FAC_W;       // channel numerator
  localparam int WN_W    = 22;                    // white numerator
  localparam int LVL_W   = 18;                    // level before the /625
  localparam int RECIP_W = 19;

  // Input limits
  localparam logic [8:0] HUE_WRAP  = 9'd360;
  localparam logic [8:0] HUE_SEC1  = 9'd120;
  localparam logic [8:0] HUE_SEC2  = 9'd240;
  localparam logic [6:0] PCT_MAX   = 7'd100;
  localparam logic [6:0] LVL_MULT  = 7'd85;

  // Level scaling: both modes end with a divide by 625 after a shift
  localparam int RGB_SH  = RATIO_FRAC_BITS + 5;
  localparam int RGBW_SH = RATIO_FRAC_BITS + 4;
  localparam int WHT_SH  = 4;
  localparam logic [LVL_W-1:0]   SAT_LIM = LVL_W'(256 * 625);
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(429497);  // ceil(2^28/625)
  localparam int RECIP_SH = 28;

  localparam logic signed [FAC_W-1:0] ONE_F =
    FAC_W'(longint'(1) << RATIO_FRAC_BITS);
  localparam logic signed [FAC_W-1:0] HUNDRED_ONE =
    FAC_W'(longint'(100) << RATIO_FRAC_BITS);
  localparam logic signed [PROD_W:0] DEN_RGB =
    (PROD_W+1)'(longint'(10000) << RATIO_FRAC_BITS);

  // Table generation constants (elaboration only)
  localparam longint PI_Q30   = 64'sd3373259426;
  localparam longint Q30_ONE  = longint'(1) << 30;
  localparam logic [63:0] Q30_HALF = 64'd1 << 29;
  localparam logic [63:0] TAYLOR_DIV [1:9] =
    '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306};
  localparam int RATIO_N = 120;

  typedef logic signed [RATIO_W-1:0] ratio_tab_t [RATIO_N];

  // Shift-subtract divide of two unsigned words
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] rem;
    int          b;
    q   = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Cosine of 0..90 degrees in Q30, Taylor series
  function automatic longint cos_q30_quad(longint d);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    int          k;
    x    = 64'((d * PI_Q30 + 64'sd90) / 180);
    x2   = (x * x + Q30_HALF) >> 30;
    term = 64'(Q30_ONE);
    sum  = Q30_ONE;
    for (k = 1; k <= 9; k++) begin
      term = (term * x2 + Q30_HALF) >> 30;
      term = term / TAYLOR_DIV[k];
      if (k[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    return sum;
  endfunction

  // Cosine of -180..180 degrees in Q30
  function automatic longint cos_q30(longint d);
    longint a;
    a = (d < 0) ? -d : d;
    if (a > 90) return -cos_q30_quad(180 - a);
    return cos_q30_quad(a);
  endfunction

  // One ratio entry, rounded half away from zero and saturated
  function automatic longint ratio_entry(int h);
    longint num;
    longint den;
    longint r;
    longint hi;
    longint lo;
    num = cos_q30(longint'(h)) * (longint'(1) << RATIO_FRAC_BITS);
    den = cos_q30(longint'(60 - h));
    hi  = (longint'(1) << (RATIO_FRAC_BITS + 1)) - 1;
    lo  = -(longint'(1) << (RATIO_FRAC_BITS + 1));
    if (den <= 0) return 0;
    if (num >= 0) r = longint'(udiv64(64'(num + (den >>> 1)), 64'(den)));
    else          r = -longint'(udiv64(64'(-num + (den >>> 1)), 64'(den)));
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r;
  endfunction

  function automatic ratio_tab_t build_ratio_tab();
    ratio_tab_t t;
    int         h;
    for (h = 0; h < RATIO_N; h++) begin
      t[h] = RATIO_W'(ratio_entry(h));
    end
    return t;
  endfunction

  localparam ratio_tab_t RATIO_TAB = build_ratio_tab();

endpackage

// ===== rtl/hsi_to_rgb_rgbw_converter_core.sv =====
// HSI to RGB / RGBW converter: six-stage pipeline, one item per clock while out_ready holds.
// Depends on hsirgbw_pkg (item types, widths, ratio table).
//
//   port group  | dir | payload     | handshake
//   ------------+-----+-------------+---------------------
//   in_*        | in  | in_item_t   | in_valid / in_ready
//   out_*       | out | out_item_t  | out_valid / out_ready
//
// An accepted item passes stage registers A to F; out_valid rises once it is
// in F. One item per clock sustained while out_ready is high. The stages are:
// clamp and sector split, ratio lookup, factor build, three channel multipliers,
// shift and saturate, divide by 625 with sector swizzle into the output register.
// rst_n (synchronous) clears the stage valid bits only. A stage holds while
// the one after it is full and stalled; empty stages fill, so bubbles close.
module hsi_to_rgb_rgbw_converter_core
  import hsirgbw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int NSTG     = 6;
  localparam int CH_LEAD  = 0;
  localparam int CH_NEXT  = 1;
  localparam int CH_THIRD = 2;
  localparam int CH_WHITE = 3;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] ld;

  // Stage A registers
  logic              a_mode_r,  a_mode_nxt;
  logic [1:0]        a_sec_r,   a_sec_nxt;
  logic [6:0]        a_h_r,     a_h_nxt;
  logic [6:0]        a_s_r,     a_s_nxt;
  logic [13:0]       a_i85_r,   a_i85_nxt;
  logic [8:0]        hue_w;
  logic [6:0]        i_c;

  // Stage B registers
  logic                      b_mode_r;
  logic [1:0]                b_sec_r;
  logic [6:0]                b_s_r;
  logic signed [RATIO_W-1:0] b_r_r,    b_r_nxt;
  logic [13:0]               b_i85_r;
  logic [K_W-1:0]            b_si85_r, b_si85_nxt;
  logic [K_W-1:0]            b_wt_r,   b_wt_nxt;

  // Stage C registers
  logic                    c_mode_r;
  logic [1:0]              c_sec_r;
  logic [K_W-1:0]          c_k_r,   c_k_nxt;
  logic signed [FAC_W-1:0] c_fac_r [3];
  logic signed [FAC_W-1:0] c_fac_nxt [3];
  logic [WN_W-1:0]         c_wn_r,  c_wn_nxt;
  logic signed [SR_W-1:0]  c_sr;
  logic signed [FAC_W-1:0] c_s_one;

  // Stage D registers
  logic                     d_mode_r;
  logic [1:0]               d_sec_r;
  logic signed [PROD_W-1:0] d_num_r [3];
  logic signed [PROD_W-1:0] d_num_nxt [3];
  logic [WN_W-1:0]          d_wn_r;

  // Stage E registers
  logic [1:0]       e_sec_r;
  logic [LVL_W-1:0] e_y_r [4];
  logic [LVL_W-1:0] e_y_nxt [4];
  logic [3:0]       e_sat_r, e_sat_nxt;

  // Stage F (output)
  out_item_t out_item_r, out_item_nxt;
  logic [7:0] lvl [4];

  // Stage load enables: a stage takes new data when empty or draining
  always_comb begin
    ld[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = vld_r[NSTG-1];
  assign out_item  = out_item_r;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (ld[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Stage A: wrap hue, split into sector and offset, clamp percentages
  always_comb begin
    hue_w = (in_item.hue_deg >= HUE_WRAP) ? in_item.hue_deg - HUE_WRAP
                                          : in_item.hue_deg;
    if (hue_w >= HUE_SEC2) begin
      a_sec_nxt = SEC_BLUE;
      a_h_nxt   = 7'(hue_w - HUE_SEC2);
    end else if (hue_w >= HUE_SEC1) begin
      a_sec_nxt = SEC_GREEN;
      a_h_nxt   = 7'(hue_w - HUE_SEC1);
    end else begin
      a_sec_nxt = SEC_RED;
      a_h_nxt   = 7'(hue_w);
    end
    a_mode_nxt = in_item.req_type;
    a_s_nxt    = (in_item.sat_pct > PCT_MAX) ? PCT_MAX : in_item.sat_pct;
    i_c        = (in_item.int_pct > PCT_MAX) ? PCT_MAX : in_item.int_pct;
    a_i85_nxt  = 14'(i_c) * 14'(LVL_MULT);
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      a_mode_r <= a_mode_nxt;
      a_sec_r  <= a_sec_nxt;
      a_h_r    <= a_h_nxt;
      a_s_r    <= a_s_nxt;
      a_i85_r  <= a_i85_nxt;
    end
  end

  // Stage B: look up the ratio, form 85*s*i and 85*(100-s)*i
  always_comb begin
    b_r_nxt    = RATIO_TAB[a_h_r];
    b_si85_nxt = K_W'(a_s_r) * K_W'(a_i85_r);
    b_wt_nxt   = K_W'(PCT_MAX - a_s_r) * K_W'(a_i85_r);
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      b_mode_r <= a_mode_r;
      b_sec_r  <= a_sec_r;
      b_s_r    <= a_s_r;
      b_r_r    <= b_r_nxt;
      b_i85_r  <= a_i85_r;
      b_si85_r <= b_si85_nxt;
      b_wt_r   <= b_wt_nxt;
    end
  end

  // Stage C: build the lead, next and third factors for the mode
  always_comb begin
    c_sr    = $signed({1'b0, b_s_r}) * b_r_r;
    c_s_one = $signed(FAC_W'(b_s_r) << RATIO_FRAC_BITS);
    if (b_mode_r == MODE_RGBW) begin
      c_fac_nxt[CH_LEAD]  = ONE_F + FAC_W'(b_r_r);
      c_fac_nxt[CH_NEXT]  = (ONE_F <<< 1) - FAC_W'(b_r_r);
      c_fac_nxt[CH_THIRD] = '0;
      c_k_nxt             = b_si85_r;
      c_wn_nxt            = (WN_W'(b_wt_r) << 1) + WN_W'(b_wt_r);
    end else begin
      c_fac_nxt[CH_LEAD]  = HUNDRED_ONE + FAC_W'(c_sr);
      c_fac_nxt[CH_NEXT]  = HUNDRED_ONE + c_s_one - FAC_W'(c_sr);
      c_fac_nxt[CH_THIRD] = $signed(FAC_W'(PCT_MAX - b_s_r) << RATIO_FRAC_BITS);
      c_k_nxt             = K_W'(b_i85_r);
      c_wn_nxt            = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      c_mode_r <= b_mode_r;
      c_sec_r  <= b_sec_r;
      c_k_r    <= c_k_nxt;
      c_fac_r  <= c_fac_nxt;
      c_wn_r   <= c_wn_nxt;
    end
  end

  // Stage D: one multiplier per colour channel
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      d_num_nxt[ch] = $signed({1'b0, c_k_r}) * c_fac_r[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      d_mode_r <= c_mode_r;
      d_sec_r  <= c_sec_r;
      d_num_r  <= d_num_nxt;
      d_wn_r   <= c_wn_r;
    end
  end

  // Stage E: round or truncate by shifting, drop non-positive, flag overflow
  always_comb begin
    logic signed [PROD_W:0] x;
    logic [PROD_W:0]        yf;
    logic                   pos;
    logic                   sat;
    logic [WN_W-1:0]        yw;
    for (int ch = 0; ch < 3; ch++) begin
      x   = $signed({d_num_r[ch], 1'b0}) + DEN_RGB;
      yf  = (d_mode_r == MODE_RGBW) ? ((PROD_W+1)'(d_num_r[ch]) >> RGBW_SH)
                                    : (x >> RGB_SH);
      pos = !d_num_r[ch][PROD_W-1] && (d_num_r[ch] != '0);
      sat = pos && (yf >= (PROD_W+1)'(SAT_LIM));
      e_sat_nxt[ch] = sat;
      e_y_nxt[ch]   = (pos && !sat) ? LVL_W'(yf) : '0;
    end
    yw  = d_wn_r >> WHT_SH;
    sat = (yw >= WN_W'(SAT_LIM));
    e_sat_nxt[CH_WHITE] = sat;
    e_y_nxt[CH_WHITE]   = sat ? '0 : LVL_W'(yw);
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      e_sec_r <= d_sec_r;
      e_y_r   <= e_y_nxt;
      e_sat_r <= e_sat_nxt;
    end
  end

  // Stage F: divide by 625 through the reciprocal, then swizzle by sector
  always_comb begin
    logic [LVL_W+RECIP_W-1:0] prod;
    for (int ch = 0; ch < 4; ch++) begin
      prod    = (LVL_W+RECIP_W)'(e_y_r[ch]) * (LVL_W+RECIP_W)'(RECIP_M);
      lvl[ch] = e_sat_r[ch] ? 8'hFF : prod[RECIP_SH +: 8];
    end
    out_item_nxt.white = lvl[CH_WHITE];
    unique case (e_sec_r)
      SEC_RED: begin
        out_item_nxt.red   = lvl[CH_LEAD];
        out_item_nxt.green = lvl[CH_NEXT];
        out_item_nxt.blue  = lvl[CH_THIRD];
      end
      SEC_GREEN: begin
        out_item_nxt.red   = lvl[CH_THIRD];
        out_item_nxt.green = lvl[CH_LEAD];
        out_item_nxt.blue  = lvl[CH_NEXT];
      end
      SEC_BLUE: begin
        out_item_nxt.red   = lvl[CH_NEXT];
        out_item_nxt.green = lvl[CH_THIRD];
        out_item_nxt.blue  = lvl[CH_LEAD];
      end
      default: begin
        out_item_nxt.red   = '0;
        out_item_nxt.green = '0;
        out_item_nxt.blue  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

// ===== tb/hsirgbw_level_checker.sv =====
`timescale 1ns / 1ps
// Checker for the HSI to RGB/RGBW converter: watches both channels, predicts
// the drive levels of every accepted pixel and compares them in order.
// Depends on hsirgbw_pkg for the item types and mode and sector codes.
module hsirgbw_level_checker
  import hsirgbw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending_count,
  output int        checked_count
);

  localparam longint ANGLE_PI_Q30 = 64'sd3373259426;
  localparam longint UNIT_Q30     = longint'(1) << 30;
  localparam longint unsigned HALF_Q30 = 64'd1 << 29;

  out_item_t expected_levels_q[$];
  int        mismatches   = 0;
  int        results_seen = 0;

  // Cosine of 0..90 degrees in Q30 by a Taylor series through the x^18 term
  function automatic longint cos_quadrant(longint deg);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    int              k;
    x    = unsigned'((deg * ANGLE_PI_Q30 + 90) / 180);
    x2   = (x * x + HALF_Q30) >> 30;
    term = unsigned'(UNIT_Q30);
    acc  = UNIT_Q30;
    for (k = 1; k <= 9; k++) begin
      term = (term * x2 + HALF_Q30) >> 30;
      term = term / unsigned'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    return acc;
  endfunction

  // Fold -180..180 degrees onto the first quadrant
  function automatic longint cos_any(longint deg);
    longint a;
    a = (deg < 0) ? -deg : deg;
    if (a > 90) return -cos_quadrant(180 - a);
    return cos_quadrant(a);
  endfunction

  // cos(h)/cos(60-h) in signed Q2.F, rounded away from zero and clipped
  function automatic longint sector_ratio(longint h);
    longint num;
    longint den;
    longint r;
    longint hi;
    longint lo;
    num = cos_any(h) * (longint'(1) << RATIO_FRAC_BITS);
    den = cos_any(60 - h);
    hi  = (longint'(1) << (RATIO_FRAC_BITS + 1)) - 1;
    lo  = -(longint'(1) << (RATIO_FRAC_BITS + 1));
    if (den <= 0) return 0;
    if (num >= 0) r = (num + den / 2) / den;
    else          r = -((-num + den / 2) / den);
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r;
  endfunction

  // Scale to a drive level, rounding half up or truncating, clipped at 255
  function automatic logic [7:0] drive_level(longint num, longint den, bit round_half);
    longint v;
    if (num <= 0) return 8'd0;
    if (round_half) v = (2 * num + den) / (2 * den);
    else            v = num / den;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Expected drive levels for one pixel
  function automatic out_item_t predict_levels(in_item_t px);
    logic [8:0] hue;
    logic [6:0] sat;
    logic [6:0] inten;
    logic [1:0] sector;
    longint     one;
    longint     den;
    longint     s;
    longint     i;
    longint     r;
    logic [7:0] lead;
    logic [7:0] nxt;
    logic [7:0] third;
    out_item_t  res;
    hue   = (px.hue_deg >= HUE_WRAP) ? px.hue_deg - HUE_WRAP : px.hue_deg;
    sat   = (px.sat_pct > PCT_MAX) ? PCT_MAX : px.sat_pct;
    inten = (px.int_pct > PCT_MAX) ? PCT_MAX : px.int_pct;
    if (hue >= HUE_SEC2)      sector = SEC_BLUE;
    else if (hue >= HUE_SEC1) sector = SEC_GREEN;
    else                      sector = SEC_RED;
    s   = longint'(sat);
    i   = longint'(inten);
    one = longint'(1) << RATIO_FRAC_BITS;
    den = 10000 * one;
    r   = sector_ratio(longint'(hue % 120));
    if (px.req_type == MODE_RGB) begin
      lead      = drive_level(85 * i * (100 * one + s * r), den, 1'b1);
      nxt       = drive_level(85 * i * (100 * one + s * (one - r)), den, 1'b1);
      third     = drive_level(85 * i * (100 - s) * one, den, 1'b1);
      res.white = 8'd0;
    end else begin
      lead      = drive_level(85 * s * i * (one + r), den, 1'b0);
      nxt       = drive_level(85 * s * i * (2 * one - r), den, 1'b0);
      third     = 8'd0;
      res.white = drive_level(255 * (100 - s) * i, 10000, 1'b0);
    end
    case (sector)
      SEC_RED: begin
        res.red = lead;  res.green = nxt;   res.blue = third;
      end
      SEC_GREEN: begin
        res.red = third; res.green = lead;  res.blue = nxt;
      end
      default: begin
        res.red = nxt;   res.green = third; res.blue = lead;
      end
    endcase
    return res;
  endfunction

  function automatic int field_diff(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  // Queue predictions on input handshakes, check on output handshakes
  always @(posedge clk) begin
    out_item_t exp_px;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_levels_q.push_back(predict_levels(in_item));
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_levels_q.size() == 0) begin
          $error("result with no pixel waiting: %h", out_item);
          mismatches++;
        end else begin
          exp_px = expected_levels_q.pop_front();
          if ((field_diff("red", exp_px.red, out_item.red) +
               field_diff("green", exp_px.green, out_item.green) +
               field_diff("blue", exp_px.blue, out_item.blue) +
               field_diff("white", exp_px.white, out_item.white)) != 0) begin
            mismatches++;
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_levels_q.size();
    checked_count <= results_seen;
  end

endmodule

// ===== tb/hsi_to_rgb_rgbw_converter_core_test.sv =====
`timescale 1ns / 1ps
// Top of the converter testbench: clock, reset, pixel stimulus with random
// idling on both channels, and the verdict. Depends on hsirgbw_pkg, the
// converter core and hsirgbw_level_checker.
module hsi_to_rgb_rgbw_converter_core_test;
  import hsirgbw_pkg::*;

  localparam int RANDOM_PIXELS = 1500;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  int        fail_count;
  int        pending_count;
  int        checked_count;
  int        sent_count;
  int        rgbw_count;
  int        last_gap;
  bit        no_gaps;

  // Directed corners: sector edges, ratio peak at zero, wrap and clamps
  int dir_hue [12] = '{0, 59, 60, 90, 91, 119, 120, 239, 240, 359, 360, 511};
  int dir_sat [12] = '{100, 100, 50, 100, 127, 0, 100, 75, 100, 101, 30, 100};
  int dir_int [12] = '{100, 50, 100, 127, 100, 100, 0, 100, 100, 60, 100, 127};

  hsi_to_rgb_rgbw_converter_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  hsirgbw_level_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short idle runs, now and then a long one
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly legal pixels, some with wrapped hue or clamped percentages
  function automatic in_item_t random_pixel();
    in_item_t px;
    px.req_type = ($urandom_range(0, 1) == 0) ? MODE_RGB : MODE_RGBW;
    px.hue_deg  = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(360, 511))
                                              : 9'($urandom_range(0, 359));
    px.sat_pct  = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
                                              : 7'($urandom_range(0, 100));
    px.int_pct  = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
                                              : 7'($urandom_range(0, 100));
    return px;
  endfunction

  // Offer one item, hold it until accepted, then idle for a random gap, which may be none
  task automatic send_pixel(in_item_t px);
    int gap;
    in_item  <= px;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    if (px.req_type == MODE_RGBW) rgbw_count++;
    gap = no_gaps ? 0 : idle_len();
    last_gap = gap;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: ready runs broken by random stalls
  initial begin
    int run;
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = idle_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    in_item_t px;
    int       n;
    int       m;
    int       waited;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    out_ready  = 1'b0;
    sent_count = 0;
    rgbw_count = 0;
    last_gap   = 0;
    no_gaps    = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners in both modes
    for (m = 0; m < 2; m++) begin
      for (n = 0; n < 12; n++) begin
        px.req_type = (m == 0) ? MODE_RGB : MODE_RGBW;
        px.hue_deg  = 9'(dir_hue[n]);
        px.sat_pct  = 7'(dir_sat[n]);
        px.int_pct  = 7'(dir_int[n]);
        send_pixel(px);
      end
    end

    // Random pixels, some blocks sent back to back
    for (n = 0; n < RANDOM_PIXELS; n++) begin
      if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_pixel(random_pixel());
    end
    if (last_gap == 0) in_valid <= 1'b0;

    // Drain the pipeline once the count covers the last item
    @(posedge clk);
    waited = 0;
    while (pending_count != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (12) @(posedge clk);
    if (pending_count != 0) $error("%0d results never arrived", pending_count);

    $display("Summary: %0d pixels sent (%0d in RGBW mode), %0d results checked",
             sent_count, rgbw_count, checked_count);
    $display("Covered sector edges, hue wrap, percentage clamps and random stalls");
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
